### design/jfps_pkg.sv
// Shared types and constants of the five-point Jacobi stencil block.
// Used by the top level, the point datapath and the port checker.
// Depends on nothing.
package jfps_pkg;

  // Data widths
  localparam int VALUE_BITS     = 16;
  localparam int NORM_BITS      = VALUE_BITS - 1;
  localparam int SIZE_BITS      = 6;
  localparam int TOL_BITS       = 15;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 15;

  // Default tile capacity (interior points per row and column)
  localparam int DEF_MAX_INTERIOR = 32;

  // Register reset values: 8 interior points, tolerance 0.01 in Q2.13
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 6'd8;
  localparam logic [TOL_BITS-1:0]  TOL_RESET  = 15'd82;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INTERIOR_SIZE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TOLERANCE     = 2'd1;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [NORM_BITS-1:0] NORM_MAX = {NORM_BITS{1'b1}};

  typedef struct packed {
    value_t old_value;
    value_t rhs_value;
  } in_item_t;

  typedef struct packed {
    value_t                new_value;
    logic                  is_ghost;
    logic                  last_of_frame;
    logic [NORM_BITS-1:0]  max_norm;
    logic                  converged;
  } out_item_t;

  // Neighborhood of one interior point
  typedef struct packed {
    value_t north;
    value_t south;
    value_t west;
    value_t east;
    value_t rhs;
  } stencil_t;

endpackage

### design/jacobi_five_point_stencil.sv
// Five-point Jacobi sweep over one (n+2)x(n+2) tile streamed row-major.
// Depends on jfps_pkg, jfps_ram and jfps_point.
//
// The block takes one grid point per cycle while the result slots can take
// stage 1, and returns results in the same order, one tile row behind. Each
// result passes the stage-1 registers, then a result slot. Points of the
// first input row give no result, and points of the last input row give two
// (the interior or border point one row up, then the bottom border point),
// so on that row the output channel sets the pace at two results per input.
// Both line rows of old values and the rhs of the previous row sit in one
// RAM of 2*(MAX_INTERIOR+2) words with one write and two read ports; the
// east neighbor is read ahead and shifted into center and west registers.
// Writing interior_size restarts the tile; tolerance takes effect at once.
module jacobi_five_point_stencil
  import jfps_pkg::*;
#(
  parameter int MAX_INTERIOR = DEF_MAX_INTERIOR
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_item_t                 out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int LINE  = MAX_INTERIOR + 2;
  localparam int CW    = $clog2(LINE);
  localparam int DEPTH = 2 * LINE;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = 2 * VALUE_BITS;
  localparam logic [SIZE_BITS-1:0] MAX_SIZE = SIZE_BITS'(MAX_INTERIOR);
  localparam logic [AW-1:0]        BANK_OFS = AW'(LINE);

  typedef struct packed {
    logic emit;
    logic ghost;
    logic last_row;
    logic last_col;
  } pos_t;

  logic [SIZE_BITS-1:0] size_r;
  logic [TOL_BITS-1:0]  tol_r;
  logic [SIZE_BITS-1:0] n_eff;
  logic [CW-1:0]        last_idx;
  logic [CW-1:0]        col_r, row_r;
  logic                 col_last, row_last;
  logic                 cfg_we, size_we;
  logic                 in_acc;
  logic [AW-1:0]        cur_base, prv_base;
  logic [AW-1:0]        wr_addr, ea_addr;
  logic [WW-1:0]        rd_a, rd_b;
  logic [WW-1:0]        ctr_r;
  value_t               west_r;
  logic                 s1_v_r;
  pos_t                 s1_pos_r;
  value_t               s1_south_r;
  stencil_t             st;
  value_t               pt_value;
  logic [NORM_BITS-1:0] pt_mag;
  logic [NORM_BITS-1:0] max_r, max_nxt;
  out_item_t            res_a, res_b;
  logic                 oa_v_r, ob_v_r;
  out_item_t            oa_r, ob_r;
  logic                 out_free, s1_move, s1_fire, pop;

  // Configuration registers
  assign cfg_ready = rst_n;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign size_we   = cfg_we && (cfg_index == CFG_INTERIOR_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
      tol_r  <= TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INTERIOR_SIZE: size_r <= cfg_data[SIZE_BITS-1:0];
        CFG_TOLERANCE:     tol_r  <= cfg_data[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp size to the supported range, derive the last row/column index
  always_comb begin
    priority if (size_r == '0) begin
      n_eff = SIZE_BITS'(1);
    end else if (size_r > MAX_SIZE) begin
      n_eff = MAX_SIZE;
    end else begin
      n_eff = size_r;
    end
    last_idx = CW'(n_eff) + CW'(1);
  end

  // Position counters of the next input point
  assign in_acc   = in_valid && in_ready;
  assign col_last = (col_r == last_idx);
  assign row_last = (row_r == last_idx);

  always_ff @(posedge clk) begin
    if (!rst_n || size_we) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (col_last) begin
        col_r <= '0;
        row_r <= row_last ? '0 : row_r + CW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // Line store addressing: bank by row parity. Port A reads the point
  // L-1 transfers back (east of center), port B the point two rows up.
  always_comb begin
    cur_base = row_r[0] ? BANK_OFS : '0;
    prv_base = row_r[0] ? '0 : BANK_OFS;
    wr_addr  = cur_base + AW'(col_r);
    ea_addr  = col_last ? cur_base : prv_base + AW'(col_r) + AW'(1);
  end

  jfps_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_line (
    .clk     (clk),
    .we      (in_acc),
    .waddr   (wr_addr),
    .wdata   ({in_data.rhs_value, in_data.old_value}),
    .re      (in_acc),
    .raddr_a (ea_addr),
    .rdata_a (rd_a),
    .raddr_b (wr_addr),
    .rdata_b (rd_b)
  );

  // Shift east read into center and west
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ctr_r      <= rd_a;
      west_r     <= ctr_r[VALUE_BITS-1:0];
      s1_south_r <= in_data.old_value;
      s1_pos_r.emit     <= (row_r != '0);
      s1_pos_r.ghost    <= (row_r == CW'(1)) || (col_r == '0) || col_last;
      s1_pos_r.last_row <= row_last;
      s1_pos_r.last_col <= col_last;
    end
  end

  // Stencil datapath
  always_comb begin
    st.north = rd_b[VALUE_BITS-1:0];
    st.south = s1_south_r;
    st.west  = west_r;
    st.east  = rd_a[VALUE_BITS-1:0];
    st.rhs   = ctr_r[WW-1:VALUE_BITS];
  end

  jfps_point u_point (
    .st        (st),
    .new_value (pt_value),
    .magnitude (pt_mag)
  );

  // Form the one or two results of the stage-1 point
  always_comb begin
    max_nxt = (!s1_pos_r.ghost && (pt_mag > max_r)) ? pt_mag : max_r;

    res_a.new_value     = s1_pos_r.ghost ? value_t'(ctr_r[VALUE_BITS-1:0]) : pt_value;
    res_a.is_ghost      = s1_pos_r.ghost;
    res_a.last_of_frame = 1'b0;
    res_a.max_norm      = max_nxt;
    res_a.converged     = 1'b0;

    res_b.new_value     = s1_south_r;
    res_b.is_ghost      = 1'b1;
    res_b.last_of_frame = s1_pos_r.last_col;
    res_b.max_norm      = max_nxt;
    res_b.converged     = s1_pos_r.last_col && (max_nxt < tol_r);
  end

  // Handshake: stage 1 advances when the result slots can take it
  assign out_free = !oa_v_r || (out_ready && !ob_v_r);
  assign s1_move  = s1_v_r && out_free;
  assign s1_fire  = s1_move && s1_pos_r.emit;
  assign pop      = oa_v_r && out_ready;
  assign in_ready = rst_n && (!s1_v_r || s1_move);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      oa_v_r <= 1'b0;
      ob_v_r <= 1'b0;
      max_r  <= '0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end

      if (s1_fire) begin
        oa_v_r <= 1'b1;
        ob_v_r <= s1_pos_r.last_row;
      end else if (pop) begin
        oa_v_r <= ob_v_r;
        ob_v_r <= 1'b0;
      end

      // Drop the running max at tile end or on restart
      if (size_we) begin
        max_r <= '0;
      end else if (s1_fire) begin
        max_r <= (s1_pos_r.last_row && s1_pos_r.last_col) ? '0 : max_nxt;
      end
    end
  end

  // Result slots
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      oa_r <= res_a;
      ob_r <= res_b;
    end else if (pop) begin
      oa_r <= ob_r;
    end
  end

  assign out_valid = oa_v_r;
  assign out_data  = oa_r;

endmodule

### design/jfps_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// Read returns the old contents on a same-address write. No dependencies.
module jfps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 68
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### design/jfps_point.sv
// Point datapath: five-term sum, quarter by arithmetic shift, saturation
// and saturated magnitude. Depends on jfps_pkg.
module jfps_point
  import jfps_pkg::*;
(
  input  stencil_t             st,
  output value_t               new_value,
  output logic [NORM_BITS-1:0] magnitude
);

  localparam int SW = VALUE_BITS + 3;

  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] quot;
  logic                 ovf;
  value_t               neg;

  // Sum the stencil and divide by four, rounding toward minus infinity
  always_comb begin
    sum  = SW'(st.north) + SW'(st.south) + SW'(st.west) + SW'(st.east) + SW'(st.rhs);
    quot = sum >>> 2;
  end

  // Saturate to the value range
  always_comb begin
    ovf = !(&quot[SW-1:VALUE_BITS-1]) && (|quot[SW-1:VALUE_BITS-1]);
    if (ovf) begin
      new_value = quot[SW-1] ? VALUE_MIN : VALUE_MAX;
    end else begin
      new_value = quot[VALUE_BITS-1:0];
    end
  end

  // Absolute value, most negative code clamps to the largest magnitude
  always_comb begin
    neg = -new_value;
    if (!new_value[VALUE_BITS-1]) begin
      magnitude = new_value[NORM_BITS-1:0];
    end else if (new_value == VALUE_MIN) begin
      magnitude = NORM_MAX;
    end else begin
      magnitude = neg[NORM_BITS-1:0];
    end
  end

endmodule

### design/jfps_checker.sv
// Port checker for the five-point Jacobi stencil, bound to the top level.
// Depends on jfps_pkg and jacobi_five_point_stencil.
module jfps_checker
  import jfps_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Flag convergence only on the final point of a tile
  a_conv_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_frame |-> !out_data.converged)
    else $error("converged set off the tile end");

  // The final point of a tile is a border point
  a_last_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_of_frame |-> out_data.is_ghost)
    else $error("tile end on an interior point");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind jacobi_five_point_stencil jfps_checker u_jfps_checker (.*);

### sim/jacobi_five_point_stencil_tb.sv
// Self-checking bench for the five-point Jacobi stencil block.
// Depends on jfps_pkg and jacobi_five_point_stencil. Runs directed and random tiles
// under random stalls on both channels and checks every result against a sweep model.
module jacobi_five_point_stencil_tb;
  import jfps_pkg::*;

  localparam int TILE_LINE     = DEF_MAX_INTERIOR + 2;
  localparam int MAX_WAIT      = 14;
  localparam int SETTLE_CYCLES = 8;
  localparam int NO_SETTLE     = 0;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int RANDOM_POINTS = 200;
  localparam int REPORT_LINES  = 40;
  localparam int RUN_LIMIT     = 10_000_000;
  localparam int TOL_SWITCH_AT = 18;
  localparam int WIDE_EXTRA    = 3 * TILE_LINE + 10;

  localparam logic [TOL_BITS-1:0] DIRECTED_TOL = 15'd3;
  localparam logic [TOL_BITS-1:0] TOL_FULL     = {TOL_BITS{1'b1}};

  // Indexes with no register behind them
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_3 = 2'd3;

  // One directed point; pinned rows carry the first result's value by hand
  typedef struct packed {
    value_t old_v;
    value_t rhs_v;
    logic   pinned;
    value_t pinned_v;
  } probe_t;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  in_item_t                  in_data   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_item_t                 out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_INTERIOR_SIZE;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  // Sweep model: registers, line stores, tile position, running max
  logic [SIZE_BITS-1:0] size_reg  = SIZE_RESET;
  logic [TOL_BITS-1:0]  tol_reg   = TOL_RESET;
  value_t               old_rows [2][TILE_LINE] = '{default: '0};
  value_t               rhs_row  [TILE_LINE]    = '{default: '0};
  int unsigned          at_row    = 0;
  int unsigned          at_col    = 0;
  logic [NORM_BITS-1:0] peak_norm = '0;
  out_item_t            pending_results [$];

  int error_count    = 0;
  int results_seen   = 0;
  int tiles_seen     = 0;
  int converged_seen = 0;
  int points_sent    = 0;
  bit src_idle       = 1'b1;
  bit sink_idle      = 1'b1;
  int sink_wait      = 0;

  probe_t directed_pts [27] = '{
    // positive extremes: top ghosts pass through, interior saturates high
    '{VALUE_MIN,    16'sd0,    1'b0, 16'sd0},
    '{VALUE_MAX,    VALUE_MIN, 1'b0, 16'sd0},
    '{16'sd1,       VALUE_MAX, 1'b0, 16'sd0},
    '{VALUE_MAX,    16'sd0,    1'b1, VALUE_MIN},
    '{16'sh5555,    VALUE_MAX, 1'b1, VALUE_MAX},
    '{VALUE_MAX,    -16'sd1,   1'b1, 16'sd1},
    '{-16'sd1,      16'sd0,    1'b1, VALUE_MAX},
    '{VALUE_MAX,    16'sd7,    1'b1, VALUE_MAX},
    '{16'sd0,       16'sd0,    1'b1, VALUE_MAX},
    // negative extremes: interior saturates low, abs of the minimum saturates
    '{16'sd0,       16'sd3,    1'b0, 16'sd0},
    '{VALUE_MIN,    16'sd0,    1'b0, 16'sd0},
    '{-16'sd2,      16'sd0,    1'b0, 16'sd0},
    '{VALUE_MIN,    16'sd0,    1'b1, 16'sd0},
    '{16'sh2AAA,    VALUE_MIN, 1'b1, VALUE_MIN},
    '{VALUE_MIN,    16'sd0,    1'b1, -16'sd2},
    '{16'sd5,       16'sd0,    1'b1, VALUE_MIN},
    '{VALUE_MIN,    16'sd0,    1'b1, VALUE_MIN},
    '{VALUE_MIN,    16'sd0,    1'b1, VALUE_MIN},
    // quarter of -5 rounds down to -2; small peak converges
    '{16'sd11,      16'sd0,    1'b0, 16'sd0},
    '{16'sd0,       16'sd0,    1'b0, 16'sd0},
    '{-16'sd11,     16'sd0,    1'b0, 16'sd0},
    '{16'sd0,       16'sd0,    1'b1, 16'sd11},
    '{16'sd77,      -16'sd5,   1'b1, 16'sd0},
    '{16'sd0,       16'sd0,    1'b1, -16'sd11},
    '{16'sd1,       16'sd0,    1'b1, 16'sd0},
    '{16'sd0,       16'sd0,    1'b1, -16'sd2},
    '{16'sd2,       16'sd0,    1'b1, 16'sd0}
  };

  jacobi_five_point_stencil u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int draw_wait(bit idling);
    return idling ? $urandom_range(0, MAX_WAIT) : 0;
  endfunction

  // Tile edge length after clamping the size register
  function automatic int unsigned tile_span();
    int unsigned n;
    n = 32'(size_reg);
    if (n < 1) n = 1;
    if (n > DEF_MAX_INTERIOR) n = DEF_MAX_INTERIOR;
    return n + 2;
  endfunction

  function automatic int unsigned points_left();
    return tile_span() * tile_span() - (at_row * tile_span() + at_col);
  endfunction

  function automatic value_t pick_value(int amp);
    if (amp == 0) return value_t'($urandom);
    return value_t'(int'($urandom_range(0, 2 * amp)) - amp);
  endfunction

  function automatic logic [SIZE_BITS-1:0] pick_size();
    case ($urandom_range(0, 7))
      0:          return '0;
      1, 2, 3, 4: return SIZE_BITS'($urandom_range(1, 3));
      5, 6:       return SIZE_BITS'($urandom_range(4, 6));
      default:    return SIZE_BITS'($urandom_range(7, 10));
    endcase
  endfunction

  function automatic logic [TOL_BITS-1:0] pick_tol();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return TOL_FULL;
      2, 3:    return TOL_BITS'($urandom_range(0, 200));
      default: return TOL_BITS'($urandom);
    endcase
  endfunction

  function automatic int pick_amp();
    case ($urandom_range(0, 3))
      1:       return 40;
      2:       return $urandom_range(1, 2000);
      default: return 0;
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic signed [31:0] got,
                               input logic signed [31:0] want);
    error_count++;
    if (error_count <= REPORT_LINES)
      $display("ERROR result %0d: %s got %0d, expected %0d", results_seen, what, got, want);
  endtask

  task automatic restart_tile();
    at_row    = 0;
    at_col    = 0;
    peak_norm = '0;
  endtask

  task automatic push_result(input value_t v, input logic ghost, input logic last);
    out_item_t e;
    e.new_value     = v;
    e.is_ghost      = ghost;
    e.last_of_frame = last;
    e.max_norm      = peak_norm;
    e.converged     = last && (peak_norm < tol_reg);
    pending_results.push_back(e);
  endtask

  // Advance the sweep by one accepted point and queue the results it releases
  task automatic sweep_point(input in_item_t pt, output int produced);
    int unsigned span, cur, prv;
    int sum, mag;
    span     = tile_span();
    cur      = at_row % 2;
    prv      = 1 - cur;
    produced = 0;
    if (at_row >= 1) begin
      if (at_row == 1 || at_col == 0 || at_col == span - 1) begin
        push_result(old_rows[prv][at_col], 1'b1, 1'b0);
      end else begin
        // rhs + west + east + north + south, quartered toward minus infinity
        sum = rhs_row[at_col] + old_rows[prv][at_col - 1] + old_rows[prv][at_col + 1]
            + old_rows[cur][at_col] + pt.old_value;
        sum = sum >>> 2;
        if (sum > VALUE_MAX) sum = VALUE_MAX;
        if (sum < VALUE_MIN) sum = VALUE_MIN;
        mag = (sum < 0) ? -sum : sum;
        if (mag > NORM_MAX) mag = NORM_MAX;
        if (mag > peak_norm) peak_norm = NORM_BITS'(mag);
        push_result(value_t'(sum), 1'b0, 1'b0);
      end
      produced = 1;
      // bottom border leaves right behind the point above it
      if (at_row == span - 1) begin
        push_result(pt.old_value, 1'b1, at_col == span - 1);
        produced = 2;
      end
    end
    old_rows[cur][at_col] = pt.old_value;
    rhs_row[at_col]       = pt.rhs_value;
    at_col++;
    if (at_col == span) begin
      at_col = 0;
      at_row++;
    end
    if (at_row == span) restart_tile();
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_INTERIOR_SIZE: begin
        size_reg = data[SIZE_BITS-1:0];
        restart_tile();
      end
      CFG_TOLERANCE: tol_reg = data[TOL_BITS-1:0];
      default: ;
    endcase
  endtask

  // Present one point after a random gap and hold it until the transfer
  task automatic send_point(input in_item_t pt, output int produced);
    int gap;
    if ($urandom_range(0, 31) == 0) src_idle = ~src_idle;
    gap = draw_wait(src_idle);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sweep_point(pt, produced);
    points_sent++;
  endtask

  // Stop sending and wait for every queued result, then let the pipe empty
  task automatic drain_results(input int settle);
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_results.size() != 0 && waited < DRAIN_LIMIT);
    if (pending_results.size() != 0) begin
      flag_mismatch("results never delivered, count", pending_results.size(), 0);
      pending_results.delete();
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic send_tile(input int unsigned count, input int amp);
    in_item_t pt;
    int produced;
    repeat (count) begin
      pt.old_value = pick_value(amp);
      pt.rhs_value = pick_value(amp);
      send_point(pt, produced);
      if ($urandom_range(0, 99) == 0) drain_results(NO_SETTLE);
    end
  endtask

  // Result side: random back-pressure, compare each transfer with the oldest expectation
  always @(posedge clk) begin
    int hold;
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_wait <= 0;
    end else if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending, new_value", out_data.new_value, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.new_value !== want.new_value)
          flag_mismatch("new_value", out_data.new_value, want.new_value);
        if (out_data.is_ghost !== want.is_ghost)
          flag_mismatch("is_ghost", out_data.is_ghost, want.is_ghost);
        if (out_data.last_of_frame !== want.last_of_frame)
          flag_mismatch("last_of_frame", out_data.last_of_frame, want.last_of_frame);
        if (out_data.max_norm !== want.max_norm)
          flag_mismatch("max_norm", out_data.max_norm, want.max_norm);
        if (out_data.converged !== want.converged)
          flag_mismatch("converged", out_data.converged, want.converged);
      end
      results_seen++;
      if (out_data.last_of_frame === 1'b1) tiles_seen++;
      if (out_data.converged === 1'b1) converged_seen++;
      if ($urandom_range(0, 39) == 0) sink_idle = ~sink_idle;
      hold = draw_wait(sink_idle);
      sink_wait <= hold;
      out_ready <= (hold == 0);
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      out_ready <= (sink_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    in_item_t pt;
    out_item_t want;
    logic [CFG_DATA_BITS-1:0] cfg_word;
    int produced, tiles, random_goal;
    int unsigned left;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: size 0 runs as one interior point, spare indexes are ignored
    write_reg(CFG_INTERIOR_SIZE, '0);
    write_reg(CFG_TOLERANCE, TOL_FULL);
    cfg_word = CFG_DATA_BITS'($urandom);
    write_reg(CFG_SPARE_2, cfg_word);
    write_reg(CFG_SPARE_3, ~cfg_word);
    foreach (directed_pts[i]) begin
      if (i == TOL_SWITCH_AT) begin
        drain_results(SETTLE_CYCLES);
        write_reg(CFG_TOLERANCE, DIRECTED_TOL);
      end
      pt.old_value = directed_pts[i].old_v;
      pt.rhs_value = directed_pts[i].rhs_v;
      send_point(pt, produced);
      if (directed_pts[i].pinned && produced != 0) begin
        want = pending_results[pending_results.size() - produced];
        want.new_value = directed_pts[i].pinned_v;
        pending_results[pending_results.size() - produced] = want;
      end
    end

    // Random phases of small tiles, some cut short before a size change
    random_goal = points_sent + RANDOM_POINTS;
    while (points_sent < random_goal) begin
      drain_results(SETTLE_CYCLES);
      if ($urandom_range(0, 2) != 0) begin
        cfg_word = CFG_DATA_BITS'($urandom);
        cfg_word[SIZE_BITS-1:0] = pick_size();
        write_reg(CFG_INTERIOR_SIZE, cfg_word);
      end
      if ($urandom_range(0, 1) != 0) write_reg(CFG_TOLERANCE, pick_tol());
      src_idle = ($urandom_range(0, 3) != 0);
      tiles = $urandom_range(1, 3);
      for (int t = 0; t < tiles; t++) begin
        left = points_left();
        if (t == tiles - 1 && $urandom_range(0, 3) == 0) left = $urandom_range(1, left);
        send_tile(left, pick_amp());
      end
    end

    // Part of the largest tile: an oversized write clamps to the capacity,
    // then a size write restarts it mid-tile
    drain_results(SETTLE_CYCLES);
    cfg_word = CFG_DATA_BITS'($urandom);
    cfg_word[SIZE_BITS-1:0] = {SIZE_BITS{1'b1}};
    write_reg(CFG_INTERIOR_SIZE, cfg_word);
    write_reg(CFG_TOLERANCE, TOL_FULL);
    send_tile(WIDE_EXTRA, 60);
    drain_results(SETTLE_CYCLES);
    write_reg(CFG_INTERIOR_SIZE, CFG_DATA_BITS'(1));
    send_tile(points_left(), 40);

    drain_results(SETTLE_CYCLES);
    $display("Swept %0d points into %0d finished tiles; %0d results checked, %0d converged.",
             points_sent, tiles_seen, results_seen, converged_seen);
    $display("Sizes from 0 up to the clamp, tolerance 0 to full scale, stalls on both sides.");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #(RUN_LIMIT);
    $display("Verification failed");
    $finish;
  end

endmodule
